// ===== src/rhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants for the RTP header parser: status codes, fixed
// header geometry and the packet length limit.
// ----------------------------------------------------------------------------
package rhp_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_BAD_LENGTH  = 2'd1;
    localparam status_t ST_BAD_VERSION = 2'd2;

    localparam int HDR_BYTES        = 12;
    localparam int WORD_BYTES       = 4;
    localparam int MAX_PACKET_BYTES = 65535;
    localparam int COUNT_W          = 17;
    localparam int LEN_W            = COUNT_W + 1;

    localparam logic [1:0] RTP_VERSION = 2'd2;

endpackage

// ===== src/rhp_in_if.sv =====
// ----------------------------------------------------------------------------
// rhp_in_if
// Byte stream channel into the parser: one packet byte and a last-byte flag
// per transaction.
// ----------------------------------------------------------------------------
interface rhp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

// ===== src/rhp_out_if.sv =====
// ----------------------------------------------------------------------------
// rhp_out_if
// Descriptor channel out of the parser: one packet descriptor per
// transaction.
// ----------------------------------------------------------------------------
interface rhp_out_if
    import rhp_pkg::*;
;

    logic        valid;
    logic        ready;
    logic [15:0] header_flags;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [15:0] ext_id;
    logic [15:0] ext_offset;
    logic [15:0] ext_length;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [7:0]  padding_length;
    status_t     status;

    modport source (
        output valid, input ready,
        output header_flags, output sequence_number, output time_stamp,
        output source_id, output ext_id, output ext_offset, output ext_length,
        output payload_offset, output payload_length, output padding_length,
        output status
    );
    modport sink (
        input valid, output ready,
        input header_flags, input sequence_number, input time_stamp,
        input source_id, input ext_id, input ext_offset, input ext_length,
        input payload_offset, input payload_length, input padding_length,
        input status
    );

endinterface

// ===== src/rtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// rtp_header_parser
// RTP fixed header and extension parser producing one descriptor per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle on pkt while pkt.ready is high and emits
// one descriptor on desc for each packet. Bytes are captured into header
// registers as they arrive; the last byte moves a snapshot of them into an
// evaluation register, and the length checks run between that register and
// the descriptor register. With desc.ready held high the block takes a byte
// every cycle, packets back to back; pkt.ready drops only while a descriptor
// is stalled with another one waiting behind it. Length faults report
// bad_length ahead of bad_version, and an errored descriptor carries zeros
// in every field but status.
module rtp_header_parser
    import rhp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    rhp_in_if.sink          pkt,
    rhp_out_if.source       desc
);

    typedef struct packed {
        logic [15:0]      flags;
        logic [15:0]      seq;
        logic [31:0]      stamp;
        logic [31:0]      source;
        logic [15:0]      ext_id;
        logic [15:0]      ext_words;
        logic [LEN_W-1:0] len;
        logic [7:0]       last_data;
    } snap_t;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // byte capture state
    logic [COUNT_W-1:0] byte_count_reg;
    logic [15:0]        flags_reg, flags_next;
    logic [15:0]        seq_reg, seq_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic [31:0]        source_reg, source_next;
    logic [15:0]        ext_id_reg, ext_id_next;
    logic [15:0]        ext_words_reg, ext_words_next;
    logic [COUNT_W-1:0] ext_pos;

    // evaluation stage
    logic               ev_valid_reg;
    snap_t              ev_reg;
    logic               out_load;
    logic               pkt_take;

    always_comb
    begin
        ext_pos        = COUNT_W'(HDR_BYTES) + {{(COUNT_W-6){1'b0}}, flags_reg[11:8], 2'b00};
        flags_next     = flags_reg;
        seq_next       = seq_reg;
        stamp_next     = stamp_reg;
        source_next    = source_reg;
        ext_id_next    = ext_id_reg;
        ext_words_next = ext_words_reg;
        if (byte_count_reg < COUNT_W'(2))
            flags_next = {flags_reg[7:0], pkt.data_byte};
        else if (byte_count_reg < COUNT_W'(4))
            seq_next = {seq_reg[7:0], pkt.data_byte};
        else if (byte_count_reg < COUNT_W'(8))
            stamp_next = {stamp_reg[23:0], pkt.data_byte};
        else if (byte_count_reg < COUNT_W'(HDR_BYTES))
            source_next = {source_reg[23:0], pkt.data_byte};
        else if (byte_count_reg == ext_pos || byte_count_reg == ext_pos + COUNT_W'(1))
            ext_id_next = {ext_id_reg[7:0], pkt.data_byte};
        else if (byte_count_reg == ext_pos + COUNT_W'(2)
                 || byte_count_reg == ext_pos + COUNT_W'(3))
            ext_words_next = {ext_words_reg[7:0], pkt.data_byte};
    end

    assign out_load  = ev_valid_reg && (!desc.valid || desc.ready);
    assign pkt.ready = !ev_valid_reg || out_load;
    assign pkt_take  = pkt.valid && pkt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            flags_reg      <= '0;
            seq_reg        <= '0;
            stamp_reg      <= '0;
            source_reg     <= '0;
            ext_id_reg     <= '0;
            ext_words_reg  <= '0;
        end
        else if (pkt_take)
        begin
            if (pkt.last_byte)
            begin
                byte_count_reg <= '0;
                flags_reg      <= '0;
                seq_reg        <= '0;
                stamp_reg      <= '0;
                source_reg     <= '0;
                ext_id_reg     <= '0;
                ext_words_reg  <= '0;
            end
            else
            begin
                if (byte_count_reg != COUNT_MAX)
                    byte_count_reg <= byte_count_reg + COUNT_W'(1);
                flags_reg     <= flags_next;
                seq_reg       <= seq_next;
                stamp_reg     <= stamp_next;
                source_reg    <= source_next;
                ext_id_reg    <= ext_id_next;
                ext_words_reg <= ext_words_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_valid_reg <= 1'b0;
        else if (pkt_take && pkt.last_byte)
            ev_valid_reg <= 1'b1;
        else if (out_load)
            ev_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pkt_take && pkt.last_byte)
        begin
            ev_reg.flags     <= flags_next;
            ev_reg.seq       <= seq_next;
            ev_reg.stamp     <= stamp_next;
            ev_reg.source    <= source_next;
            ev_reg.ext_id    <= ext_id_next;
            ev_reg.ext_words <= ext_words_next;
            ev_reg.len       <= {1'b0, byte_count_reg} + LEN_W'(1);
            ev_reg.last_data <= pkt.data_byte;
        end
    end

    // length and version checks on the snapshot
    logic             has_x, has_p;
    logic [LEN_W-1:0] csrc_end, rem, words4, elen, pl_start, plen, plen_net, pad_w;
    logic             bad_len;
    status_t          status_next;

    always_comb
    begin
        has_x    = ev_reg.flags[12];
        has_p    = ev_reg.flags[13];
        csrc_end = LEN_W'(HDR_BYTES) + {{(LEN_W-6){1'b0}}, ev_reg.flags[11:8], 2'b00};
        rem      = ev_reg.len - csrc_end;
        words4   = {ev_reg.ext_words, 2'b00};
        elen     = words4 + LEN_W'(WORD_BYTES);
        pad_w    = {{(LEN_W-8){1'b0}}, ev_reg.last_data};
        bad_len  = ev_reg.len < LEN_W'(HDR_BYTES)
                   || ev_reg.len > LEN_W'(MAX_PACKET_BYTES)
                   || ev_reg.len < csrc_end;
        if (has_x && (rem < LEN_W'(WORD_BYTES) || rem - LEN_W'(WORD_BYTES) < words4))
            bad_len = 1'b1;
        pl_start = has_x ? csrc_end + elen : csrc_end;
        plen     = ev_reg.len - pl_start;
        plen_net = plen;
        if (has_p)
        begin
            if (plen == '0 || pad_w > plen)
                bad_len = 1'b1;
            plen_net = plen - pad_w;
        end
        if (bad_len)
            status_next = ST_BAD_LENGTH;
        else if (ev_reg.flags[15:14] != RTP_VERSION)
            status_next = ST_BAD_VERSION;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            desc.valid <= 1'b0;
        else if (out_load)
            desc.valid <= 1'b1;
        else if (desc.ready)
            desc.valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            desc.status <= status_next;
            if (status_next == ST_OK)
            begin
                desc.header_flags    <= ev_reg.flags;
                desc.sequence_number <= ev_reg.seq;
                desc.time_stamp      <= ev_reg.stamp;
                desc.source_id       <= ev_reg.source;
                desc.ext_id          <= has_x ? ev_reg.ext_id : '0;
                desc.ext_offset      <= has_x ? csrc_end[15:0] : '0;
                desc.ext_length      <= has_x ? elen[15:0] : '0;
                desc.payload_offset  <= pl_start[15:0];
                desc.payload_length  <= plen_net[15:0];
                desc.padding_length  <= has_p ? ev_reg.last_data : '0;
            end
            else
            begin
                desc.header_flags    <= '0;
                desc.sequence_number <= '0;
                desc.time_stamp      <= '0;
                desc.source_id       <= '0;
                desc.ext_id          <= '0;
                desc.ext_offset      <= '0;
                desc.ext_length      <= '0;
                desc.payload_offset  <= '0;
                desc.payload_length  <= '0;
                desc.padding_length  <= '0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.ready && pkt.last_byte |=> byte_count_reg == '0)
        else $error("capture state not cleared after last byte");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        desc.valid && desc.status != ST_OK |->
            desc.header_flags == '0 && desc.payload_offset == '0
            && desc.payload_length == '0 && desc.source_id == '0)
        else $error("errored descriptor carries nonzero fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        desc.valid |-> desc.status == ST_OK || desc.status == ST_BAD_LENGTH
            || desc.status == ST_BAD_VERSION)
        else $error("undefined status code");

    a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        desc.valid && desc.status == ST_OK |-> desc.payload_offset >= 16'(HDR_BYTES))
        else $error("payload offset inside fixed header");

    a_no_lost_descriptor: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg && !out_load |=> ev_valid_reg)
        else $error("pending descriptor dropped");
`endif

endmodule
